// ----- src/qoi_pkg.sv -----
// QOI chunk decoder package: word types for the byte and pixel channels,
// pixel count width and the reset pixel. No dependencies.
package qoi_pkg;

   localparam int PixCntWidth = 32;          // 16 .. 32
   localparam int CsrAddrWidth = 3;
   localparam logic [31:0] ResetPixel = 32'h0000_00FF;   // opaque black

   // register byte addresses
   localparam logic [CsrAddrWidth-1:0] CSR_IMAGE_PIXELS = 3'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_image;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_of_chunk;
      logic       last_of_image;
   } rsp_word_type;

endpackage

// ----- src/qoi_chunk_decoder_core.sv -----
// QOI chunk decoder top level: byte channel in, RGBA pixel channel out,
// APB-style pixel count register. Depends on qoi_pkg.
//
// Takes the chunk stream after the header one byte per cycle unless
// req_stall is raised, and returns one pixel word per cycle while rsp_stall
// is low. The colour index memory is read at the edge that accepts a byte.
// The byte is decoded in the following cycle, and its pixel is registered
// into the output register when the byte leaves decode. A run byte holds
// the output register until all of its pixels (up to 62) have been taken.
// The next byte that gives a pixel waits in decode until the last of them
// leaves. Other bytes do not wait in decode, so throughput is one byte a cycle
// outside runs and output stalls. The colour index is cleared at once by
// start_image or reset through per-entry valid bits; there is no clearing
// pass. Tag bytes and inner bytes of RGB, RGBA and LUMA give no pixel, and
// bytes after the last pixel of the image are dropped until start_image.
module qoi_chunk_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  qoi_pkg::req_word_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qoi_pkg::rsp_word_type             rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qoi_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import qoi_pkg::*;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_RGB,
      OP_RGBA,
      OP_LUMA
   } op_type;

   function automatic logic [5:0] hash_slot(input logic [31:0] p);
      logic [5:0] r, g, b, a;
      r = p[29:24];
      g = p[21:16];
      b = p[13:8];
      a = p[5:0];
      hash_slot = r * 6'd3 + g * 6'd5 + b * 6'd7 + a * 6'd11;
   endfunction

   // configuration
   logic [31:0] cfg_pixels_ff;
   logic        csr_write;

   // lookup stage
   logic [31:0] color_index_mem [64];
   logic [63:0] entry_valid_ff, entry_valid_in;
   logic [31:0] rd_data_ff;
   logic        rd_valid_ff, rd_valid_in;
   logic        fwd_hit_ff, fwd_hit_in;
   logic [31:0] fwd_data_ff;
   logic [5:0]  rd_addr;
   logic        req_accept;

   // decode stage
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_start_ff;

   logic [31:0]            prev_ff, prev_in, prev_cur;
   op_type                 op_ff, op_in, op_cur;
   logic [2:0]             gcnt_ff, gcnt_in, gcnt_cur, gcnt_next;
   logic [31:0]            gdata_ff, gdata_in, gdata_cur, gdata_next;
   logic [PixCntWidth-1:0] emitted_ff, emitted_in, emitted_cur;
   logic [PixCntWidth-1:0] limit, remaining;
   logic [31:0]            entry, pix;
   logic [5:0]             rep, rep_eff;
   logic [2:0]             need;
   logic [7:0]             pr, pg, pb, pa, dg;
   logic                   have_pix, done, trunc, img_end, emits, fire;

   // output stage
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_pix_ff;
   logic [5:0]  out_cnt_ff, out_cnt_in;
   logic        out_end_ff;
   logic        out_take, out_free;

   logic        wr_en;
   logic [5:0]  wr_addr;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CsrAddrWidth-1:2] == CSR_IMAGE_PIXELS[CsrAddrWidth-1:2])
                       ? cfg_pixels_ff : 32'd0;

   assign out_take = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || (out_take && out_cnt_ff == 6'd1);

   assign rsp_valid              = out_valid_ff;
   assign rsp_data.red           = out_pix_ff[31:24];
   assign rsp_data.green         = out_pix_ff[23:16];
   assign rsp_data.blue          = out_pix_ff[15:8];
   assign rsp_data.alpha         = out_pix_ff[7:0];
   assign rsp_data.last_of_chunk = (out_cnt_ff == 6'd1);
   assign rsp_data.last_of_image = (out_cnt_ff == 6'd1) && out_end_ff;

   assign req_stall  = s1_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;
   assign rd_addr    = req_data.data_byte[5:0];

   // decode
   always_comb begin
      prev_cur    = s1_start_ff ? ResetPixel : prev_ff;
      op_cur      = s1_start_ff ? OP_NONE : op_ff;
      gcnt_cur    = s1_start_ff ? 3'd0 : gcnt_ff;
      gdata_cur   = s1_start_ff ? 32'd0 : gdata_ff;
      emitted_cur = s1_start_ff ? '0 : emitted_ff;

      // a start byte sees an empty index; same-edge writes come via forwarding
      if (s1_start_ff)      entry = 32'd0;
      else if (fwd_hit_ff)  entry = fwd_data_ff;
      else if (rd_valid_ff) entry = rd_data_ff;
      else                  entry = 32'd0;

      limit     = cfg_pixels_ff[PixCntWidth-1:0];
      done      = (emitted_cur >= limit);
      remaining = limit - emitted_cur;

      pr = prev_cur[31:24];
      pg = prev_cur[23:16];
      pb = prev_cur[15:8];
      pa = prev_cur[7:0];
      dg = {2'b00, gdata_cur[5:0]};

      gdata_next = {gdata_cur[23:0], s1_byte_ff};
      gcnt_next  = gcnt_cur + 3'd1;
      case (op_cur)
         OP_RGB:  need = 3'd3;
         OP_RGBA: need = 3'd4;
         default: need = 3'd1;
      endcase

      have_pix = 1'b0;
      pix      = prev_cur;
      rep      = 6'd1;
      op_in    = op_cur;
      gcnt_in  = gcnt_cur;
      gdata_in = gdata_cur;

      if (op_cur != OP_NONE) begin
         if (gcnt_next < need) begin
            gcnt_in  = gcnt_next;
            gdata_in = gdata_next;
         end else begin
            have_pix = 1'b1;
            op_in    = OP_NONE;
            gcnt_in  = 3'd0;
            gdata_in = 32'd0;
            case (op_cur)
               OP_RGB:  pix = {gdata_next[23:0], pa};
               OP_RGBA: pix = gdata_next;
               default: pix = {pr + dg + {4'h0, s1_byte_ff[7:4]} - 8'd40,
                               pg + dg - 8'd32,
                               pb + dg + {4'h0, s1_byte_ff[3:0]} - 8'd40,
                               pa};
            endcase
         end
      end else if (s1_byte_ff == 8'hFE || s1_byte_ff == 8'hFF) begin
         op_in    = (s1_byte_ff == 8'hFE) ? OP_RGB : OP_RGBA;
         gcnt_in  = 3'd0;
         gdata_in = 32'd0;
      end else begin
         case (s1_byte_ff[7:6])
            2'b00: begin
               have_pix = 1'b1;
               pix      = entry;
            end
            2'b01: begin
               have_pix = 1'b1;
               pix = {pr + {6'd0, s1_byte_ff[5:4]} - 8'd2,
                      pg + {6'd0, s1_byte_ff[3:2]} - 8'd2,
                      pb + {6'd0, s1_byte_ff[1:0]} - 8'd2,
                      pa};
            end
            2'b10: begin
               op_in    = OP_LUMA;
               gcnt_in  = 3'd0;
               gdata_in = {24'd0, s1_byte_ff};
            end
            default: begin
               have_pix = 1'b1;
               rep      = s1_byte_ff[5:0] + 6'd1;
            end
         endcase
      end

      // cut a run at the end of the image
      trunc   = (remaining[PixCntWidth-1:6] == '0) && (remaining[5:0] < rep);
      img_end = (remaining[PixCntWidth-1:6] == '0) && (remaining[5:0] <= rep);
      rep_eff = trunc ? remaining[5:0] : rep;

      emits = have_pix && !done;
      fire  = s1_valid_ff && (!emits || out_free);

      prev_in    = prev_cur;
      emitted_in = emitted_cur;
      if (done) begin
         op_in    = op_cur;
         gcnt_in  = gcnt_cur;
         gdata_in = gdata_cur;
      end else if (have_pix) begin
         prev_in    = pix;
         emitted_in = trunc ? limit : emitted_cur + PixCntWidth'(rep);
      end

      wr_en   = fire && emits;
      wr_addr = hash_slot(pix);
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (fire && s1_start_ff) entry_valid_in = '0;
      if (wr_en)               entry_valid_in[wr_addr] = 1'b1;

      fwd_hit_in  = wr_en && (wr_addr == rd_addr);
      rd_valid_in = entry_valid_ff[rd_addr] && !(fire && s1_start_ff);

      if (req_accept)  s1_valid_in = 1'b1;
      else if (fire)   s1_valid_in = 1'b0;
      else             s1_valid_in = s1_valid_ff;

      out_valid_in = out_valid_ff;
      out_cnt_in   = out_cnt_ff;
      if (out_take) begin
         if (out_cnt_ff == 6'd1) out_valid_in = 1'b0;
         else                    out_cnt_in   = out_cnt_ff - 6'd1;
      end
      if (wr_en) begin
         out_valid_in = 1'b1;
         out_cnt_in   = rep_eff;
      end
   end

   // colour index memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) color_index_mem[wr_addr] <= pix;
      if (req_accept) rd_data_ff <= color_index_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pixels_ff  <= 32'd1;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         prev_ff        <= ResetPixel;
         op_ff          <= OP_NONE;
         gcnt_ff        <= 3'd0;
         gdata_ff       <= 32'd0;
         emitted_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write && csr_pready &&
             csr_paddr[CsrAddrWidth-1:2] == CSR_IMAGE_PIXELS[CsrAddrWidth-1:2]) begin
            cfg_pixels_ff <= csr_pwdata;
         end
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         if (fire) begin
            prev_ff    <= prev_in;
            op_ff      <= op_in;
            gcnt_ff    <= gcnt_in;
            gdata_ff   <= gdata_in;
            emitted_ff <= emitted_in;
         end
      end
      // payload
      if (req_accept) begin
         s1_byte_ff  <= req_data.data_byte;
         s1_start_ff <= req_data.start_image;
         rd_valid_ff <= rd_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= pix;
      end
      out_cnt_ff <= out_cnt_in;
      if (wr_en) begin
         out_pix_ff <= pix;
         out_end_ff <= img_end;
      end
   end

endmodule

// ----- sim/tb_qoi_chunk_decoder_core.sv -----
// Self-checking testbench for qoi_chunk_decoder_core: decodes every accepted byte
// in a scoreboard class and compares the pixel words that come back in order.
// Depends on qoi_pkg and qoi_chunk_decoder_core.
`timescale 1ns / 100ps

module tb_qoi_chunk_decoder_core;
   import qoi_pkg::*;

   localparam int          RANDOM_BYTES   = 320;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          SETTLE_CYCLES  = 6;
   localparam logic [31:0] COUNT_MASK     = 32'((64'd1 << PixCntWidth) - 64'd1);

   localparam logic [7:0] OP_RGB   = 8'hFE;
   localparam logic [7:0] OP_RGBA  = 8'hFF;
   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;
   localparam logic [7:0] END_PAD  = 8'h00;
   localparam logic [7:0] END_LAST = 8'h01;

   typedef enum logic [1:0] {CHUNK_NONE, CHUNK_RGB, CHUNK_RGBA, CHUNK_LUMA} chunk_kind_type;

   class pixel_checker;
      logic [31:0]    color_index [64];
      logic [31:0]    prev_pixel;
      chunk_kind_type pending_kind;
      int unsigned    gathered_count;
      logic [31:0]    gathered_bytes;
      logic [31:0]    pixels_done;
      logic [31:0]    pixel_total;
      rsp_word_type   expected_pixels [$];
      int unsigned    mismatches;
      int unsigned    live_bytes;
      int unsigned    checked;

      function new();
         pixel_total = 32'd1;
         mismatches  = 0;
         live_bytes  = 0;
         checked     = 0;
         restart_image();
      endfunction

      function void restart_image();
         foreach (color_index[i]) color_index[i] = '0;
         prev_pixel     = ResetPixel;
         pending_kind   = CHUNK_NONE;
         gathered_count = 0;
         gathered_bytes = '0;
         pixels_done    = '0;
      endfunction

      function bit image_complete();
         return pixels_done >= (pixel_total & COUNT_MASK);
      endfunction

      function logic [5:0] colour_slot(logic [31:0] p);
         return 6'((p[31:24] * 3 + p[23:16] * 5 + p[15:8] * 7 + p[7:0] * 11) % 64);
      endfunction

      function void decode_byte(req_word_type w);
         logic [7:0]   b, pr, pg, pb, pa;
         logic [31:0]  lim, pix, left;
         logic [5:0]   dg;
         logic [3:0]   drdg, dbdg;
         int unsigned  rep, need;
         rsp_word_type px;
         b = w.data_byte;
         if (w.start_image) restart_image();
         lim = pixel_total & COUNT_MASK;
         if (pixels_done >= lim) return;
         live_bytes++;
         {pr, pg, pb, pa} = prev_pixel;
         rep = 1;
         if (pending_kind != CHUNK_NONE) begin
            gathered_bytes = {gathered_bytes[23:0], b};
            gathered_count = (gathered_count + 1) & 7;
            need = (pending_kind == CHUNK_RGB) ? 3 : (pending_kind == CHUNK_RGBA) ? 4 : 1;
            if (gathered_count < need) return;
            case (pending_kind)
               CHUNK_RGB:  pix = {gathered_bytes[23:0], pa};
               CHUNK_RGBA: pix = gathered_bytes;
               default: begin
                  dg   = gathered_bytes[13:8];
                  drdg = b[7:4];
                  dbdg = b[3:0];
                  pix  = {8'(pr + dg + drdg - 8'd40), 8'(pg + dg - 8'd32),
                          8'(pb + dg + dbdg - 8'd40), pa};
               end
            endcase
            pending_kind   = CHUNK_NONE;
            gathered_count = 0;
            gathered_bytes = '0;
         end else if (b == OP_RGB || b == OP_RGBA) begin
            pending_kind   = (b == OP_RGB) ? CHUNK_RGB : CHUNK_RGBA;
            gathered_count = 0;
            gathered_bytes = '0;
            return;
         end else begin
            case (b[7:6])
               TAG_INDEX: pix = color_index[b[5:0]];
               TAG_DIFF:  pix = {8'(pr + b[5:4] - 8'd2), 8'(pg + b[3:2] - 8'd2),
                                 8'(pb + b[1:0] - 8'd2), pa};
               TAG_LUMA: begin
                  pending_kind   = CHUNK_LUMA;
                  gathered_count = 0;
                  gathered_bytes = {24'd0, b};
                  return;
               end
               default: begin
                  pix = prev_pixel;
                  rep = b[5:0] + 1;
               end
            endcase
         end
         prev_pixel = pix;
         color_index[colour_slot(pix)] = pix;
         left = lim - pixels_done;
         if (rep > left) rep = left;
         for (int k = 0; k < rep; k++) begin
            pixels_done = (pixels_done + 32'd1) & COUNT_MASK;
            {px.red, px.green, px.blue, px.alpha} = pix;
            px.last_of_chunk = (k + 1 == rep);
            px.last_of_image = (pixels_done == lim);
            expected_pixels.push_back(px);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("pixel %0d %s: got %0h, want %0h",
                                      checked, name, got, want));
      endtask

      task check_pixel(rsp_word_type got);
         rsp_word_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %0d arrived with none outstanding", checked));
            checked++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("red", got.red, want.red);
         compare_field("green", got.green, want.green);
         compare_field("blue", got.blue, want.blue);
         compare_field("alpha", got.alpha, want.alpha);
         compare_field("last_of_chunk", 8'(got.last_of_chunk), 8'(want.last_of_chunk));
         compare_field("last_of_image", 8'(got.last_of_image), 8'(want.last_of_image));
         checked++;
      endtask

      task flush_outstanding();
         while (expected_pixels.size() != 0) begin
            void'(expected_pixels.pop_front());
            report_mismatch("expected pixel never arrived");
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_word_type            req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_word_type            rsp_data;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   pixel_checker chk = new();
   int unsigned  burst_left = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  stall_mode = 0;
   int unsigned  mode_left = 0;

   qoi_chunk_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: quiet, choppy and heavy stretches of stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            chk.decode_byte(req_data);
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            chk.check_pixel(rsp_data);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("qoi_chunk_decoder_core: mismatch");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      req_word_type w;
      int unsigned  gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      w.data_byte   = b;
      w.start_image = start;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender until every pixel is back and the pipe has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (chk.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_IMAGE_PIXELS;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // read old value, write, read back; only called once drained
   task automatic program_pixel_count(input logic [31:0] count);
      logic [31:0] rd;
      apb_cycle(1'b0, '0, rd);
      if (rd !== chk.pixel_total)
         chk.report_mismatch($sformatf("image_pixels read %0h, want %0h", rd, chk.pixel_total));
      apb_cycle(1'b1, count, rd);
      chk.pixel_total = count;
      apb_cycle(1'b0, '0, rd);
      if (rd !== count)
         chk.report_mismatch($sformatf("image_pixels read %0h, want %0h", rd, count));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_chunk(input logic start);
      int unsigned len;
      case ($urandom_range(0, 9))
         0: begin
            send_byte(OP_RGB, start);
            repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         1: begin
            send_byte(OP_RGBA, start);
            repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         2, 3: send_byte({TAG_INDEX, 6'($urandom_range(0, 63))}, start);
         4, 5: send_byte({TAG_DIFF, 6'($urandom_range(0, 63))}, start);
         6, 7: begin
            send_byte({TAG_LUMA, 6'($urandom_range(0, 63))}, start);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         8: begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 61) : $urandom_range(0, 7);
            send_byte({TAG_RUN, 6'(len)}, start);
         end
         // noise, which may also break a gathered op with a restart
         default: send_byte(8'($urandom_range(0, 255)),
                            start | ($urandom_range(0, 3) == 0));
      endcase
   endtask

   initial begin
      int unsigned target, budget, sel;
      logic [31:0] count;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of one: a single pixel, then the image is complete
      send_byte({TAG_DIFF, 6'h3F}, 1'b0);
      send_byte(END_PAD, 1'b0);
      send_byte({TAG_INDEX, 6'h15}, 1'b1);
      drain();

      // zero pixel count ignores everything
      program_pixel_count(32'd0);
      send_byte({TAG_RUN, 6'h05}, 1'b1);
      send_byte({TAG_DIFF, 6'h00}, 1'b0);
      drain();

      // every op at its extremes; the long run is cut at the image end
      program_pixel_count(32'd40);
      send_byte(OP_RGB, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(OP_RGBA, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte({TAG_INDEX, 6'h00}, 1'b0);
      send_byte({TAG_INDEX, 6'h3F}, 1'b0);
      send_byte({TAG_DIFF, 6'h00}, 1'b0);
      send_byte({TAG_DIFF, 6'h3F}, 1'b0);
      send_byte({TAG_LUMA, 6'h00}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte({TAG_LUMA, 6'h3F}, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte({TAG_RUN, 6'h00}, 1'b0);
      send_byte({TAG_RUN, 6'h3D}, 1'b0);
      send_byte(END_PAD, 1'b0);
      send_byte(END_LAST, 1'b0);
      // restart in the middle of a LUMA pair
      send_byte({TAG_LUMA, 6'h11}, 1'b1);
      send_byte(OP_RGB, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      drain();

      // count changed mid-image: down to what is done, then up to the maximum
      program_pixel_count(32'd1);
      send_byte({TAG_DIFF, 6'h2A}, 1'b0);
      drain();
      program_pixel_count(32'hFFFF_FFFF);
      send_byte({TAG_DIFF, 6'h2A}, 1'b0);
      send_byte({TAG_RUN, 6'h02}, 1'b0);

      target = chk.live_bytes + RANDOM_BYTES;
      while (chk.live_bytes < target) begin
         sel = $urandom_range(0, 11);
         if (sel == 0)
            count = $urandom_range(1, 3);
         else if (sel == 1)
            count = 32'hFFFF_FFFF;
         else
            count = $urandom_range(8, 120);
         if (sel != 11) begin
            drain();
            program_pixel_count(count);
         end
         budget = $urandom_range(20, 80);
         random_chunk(1'b1);
         while (!chk.image_complete() && budget > 0) begin
            random_chunk(1'b0);
            budget--;
            if ($urandom_range(0, 40) == 0) drain();
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat (7) send_byte(END_PAD, 1'b0);
            send_byte(END_LAST, 1'b0);
         end
      end

      drain();
      chk.flush_outstanding();
      if (chk.mismatches == 0)
         $display("qoi_chunk_decoder_core: match");
      else
         $display("qoi_chunk_decoder_core: mismatch");
      $finish;
   end

endmodule

// ----- qoi_chunk_decoder_core.f -----
src/qoi_pkg.sv
src/qoi_chunk_decoder_core.sv
sim/tb_qoi_chunk_decoder_core.sv
